@@ rtl/core/hctb_pkg.sv @@
// ----------------------------------------------------------------------------
// hctb_pkg: shared types and constants of the hashed context byte table
// Table geometry, hash constants and the packed layout of one table row.
// ----------------------------------------------------------------------------
package hctb_pkg;

  // Table geometry; TABLE_ENTRIES is a power of two so the home index is
  // the low bits of the hash and the probe wraps by overflow.
  localparam int TABLE_ENTRIES = 4096;
  localparam int TOP_SLOTS     = 4;
  localparam int PROBE_LIMIT   = 16;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int PROBE_W = $clog2(PROBE_LIMIT + 1);
  localparam int SLOT_W  = (TOP_SLOTS > 1) ? $clog2(TOP_SLOTS) : 1;

  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;
  localparam int          HALF_W    = 32;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_UPDATE  = 1'b1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [PROBE_W-1:0] probe_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  typedef struct packed {
    logic [63:0]                key;
    logic [31:0]                total;
    logic [TOP_SLOTS-1:0][7:0]  sbyte;
    logic [TOP_SLOTS-1:0][31:0] scount;
  } row_t;

  // Hash unit handshake
  typedef struct packed {
    logic done;
    idx_t idx;
  } hash_stat_t;

endpackage

@@ rtl/core/hctb_ifs.sv @@
// ----------------------------------------------------------------------------
// hctb_ifs: request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface hctb_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] context_key;
  logic [7:0]  target_byte;

  modport source (output valid, action, context_key, target_byte, input ready);
  modport sink   (input valid, action, context_key, target_byte, output ready);
endinterface

interface hctb_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slot_byte;
  logic [31:0] slot_count;
  logic [31:0] entry_total;
  logic        key_matched;
  logic        last;

  modport source (output valid, slot_byte, slot_count, entry_total, key_matched, last,
                  input ready);
  modport sink   (input valid, slot_byte, slot_count, entry_total, key_matched, last,
                  output ready);
endinterface

@@ rtl/core/hctb_row_mem.sv @@
// ----------------------------------------------------------------------------
// hctb_row_mem: table row memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hctb_row_mem (
  input  logic          clk,
  input  logic          we,
  input  hctb_pkg::idx_t waddr,
  input  hctb_pkg::row_t wdata,
  input  hctb_pkg::idx_t raddr,
  output hctb_pkg::row_t rdata
);
  import hctb_pkg::*;

  row_t mem [TABLE_ENTRIES];

  // Write row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/hctb_hash.sv @@
// ----------------------------------------------------------------------------
// hctb_hash: iterative 64-bit mix finalizer
// Each 64x64 low-half product is built from partial products on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module hctb_hash (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         key,
  output hctb_pkg::hash_stat_t stat
);
  import hctb_pkg::*;

  typedef enum logic [1:0] {
    H_IDLE = 2'b01,
    H_RUN  = 2'b10
  } hstate_t;

  hstate_t     state;
  logic [1:0]  phase;
  logic        second;
  logic [63:0] h;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] cst;
  logic [63:0] sum;
  logic [63:0] mixed;

  // Pick operand halves for the current partial product
  always_comb begin
    cst = second ? MIX_C2 : MIX_C1;
    unique case (phase)
      2'd0:    begin op_a = h[31:0];  op_b = cst[31:0];  end
      2'd1:    begin op_a = h[63:32]; op_b = cst[31:0];  end
      2'd2:    begin op_a = h[31:0];  op_b = cst[63:32]; end
      default: begin op_a = h[31:0];  op_b = cst[31:0];  end
    endcase
    sum   = acc + {prod[HALF_W-1:0], 32'b0};
    mixed = sum ^ (sum >> MIX_SHIFT);
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= 64'(op_a) * 64'(op_b);
  end

  // Sequence the partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= H_IDLE;
      phase     <= 2'd0;
      second    <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (start) begin
            h      <= key ^ (key >> MIX_SHIFT);
            phase  <= 2'd0;
            second <= 1'b0;
            state  <= H_RUN;
          end
        end
        H_RUN: begin
          phase <= phase + 2'd1;
          unique case (phase)
            2'd0: ;
            2'd1: acc <= prod;
            2'd2: acc <= sum;
            default: begin
              h <= mixed;
              if (second) begin
                stat.idx  <= mixed[IDX_W-1:0];
                stat.done <= 1'b1;
                state     <= H_IDLE;
              end else begin
                second <= 1'b1;
              end
            end
          endcase
        end
        default: state <= H_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/hashed_context_top_byte_table_unit.sv @@
// ----------------------------------------------------------------------------
// hashed_context_top_byte_table_unit: hashed context table with top bytes
// Hashes a context key, probes the table linearly, then reports or trains
// the selected entry.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  request   in   action, context_key, target_byte
//  result    out  slot_byte, slot_count, entry_total, key_matched, last
//
//  The hash runs on the shared 32x32 multiplier; probing makes 1 to
//  PROBE_LIMIT+1 table reads; a predict then emits TOP_SLOTS results, and
//  an update writes the trained row back. A new request is taken only once
//  the last is done. After reset a clearing pass writes TABLE_ENTRIES rows
//  before the first request is taken. Result stalls hold the emit sequence.
// ----------------------------------------------------------------------------
module hashed_context_top_byte_table_unit (
  input logic       clk,
  input logic       rst,
  hctb_req_if.sink  request,
  hctb_res_if.source result
);
  import hctb_pkg::*;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_HASH = 6'b000100,
    S_CHK  = 6'b001000,
    S_EMIT = 6'b010000,
    S_WR   = 6'b100000
  } state_t;

  state_t      state;
  idx_t        clr_idx;
  idx_t        cur_idx;
  probe_t      probe_cnt;
  slot_t       slot_k;
  logic        act;
  logic [63:0] key;
  logic [7:0]  target;
  row_t        row;
  row_t        rdata;
  row_t        upd_row;
  row_t        wdata;
  idx_t        raddr;
  idx_t        waddr;
  logic        mem_we;
  logic        hit;
  hash_stat_t  hstat;
  logic        load_out;
  logic        found;

  assign request.ready = (state == S_IDLE);

  hctb_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (request.valid && request.ready),
    .key   (request.context_key),
    .stat  (hstat)
  );

  hctb_row_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read address: home slot from the hash, then the next probe
  assign raddr = (state == S_HASH) ? hstat.idx : cur_idx + idx_t'(1);
  assign hit   = (rdata.total == 32'd0) || (rdata.key == key);

  // Build the trained row
  always_comb begin
    upd_row = row;
    found   = 1'b0;
    if (row.key != key) begin
      upd_row       = '0;
      upd_row.key   = key;
    end
    if (upd_row.total != COUNT_MAX) upd_row.total = upd_row.total + 32'd1;
    for (int n = 0; n < TOP_SLOTS; n++) begin
      if (!found && upd_row.scount[n] != 32'd0 && upd_row.sbyte[n] == target) begin
        found = 1'b1;
        if (upd_row.scount[n] != COUNT_MAX) upd_row.scount[n] = upd_row.scount[n] + 32'd1;
      end
    end
    for (int n = 0; n < TOP_SLOTS; n++) begin
      if (!found && upd_row.scount[n] == 32'd0) begin
        found              = 1'b1;
        upd_row.sbyte[n]   = target;
        upd_row.scount[n]  = 32'd1;
      end
    end
  end

  // Write port: clearing pass or trained row
  assign mem_we = (state == S_CLR) || (state == S_WR);
  assign waddr  = (state == S_CLR) ? clr_idx : cur_idx;
  assign wdata  = (state == S_CLR) ? row_t'('0) : upd_row;

  assign load_out = (state == S_EMIT) && (!result.valid || result.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_idx      <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && !load_out) result.valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + idx_t'(1);
          if (clr_idx == idx_t'(TABLE_ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (request.valid) begin
            act    <= request.action;
            key    <= request.context_key;
            target <= request.target_byte;
            state  <= S_HASH;
          end
        end
        S_HASH: begin
          if (hstat.done) begin
            cur_idx   <= hstat.idx;
            probe_cnt <= '0;
            state     <= S_CHK;
          end
        end
        S_CHK: begin
          if (hit || probe_cnt == probe_t'(PROBE_LIMIT)) begin
            row    <= rdata;
            slot_k <= '0;
            state  <= (act == ACT_UPDATE) ? S_WR : S_EMIT;
          end else begin
            cur_idx   <= cur_idx + idx_t'(1);
            probe_cnt <= probe_cnt + probe_t'(1);
          end
        end
        S_EMIT: begin
          if (load_out) begin
            result.valid       <= 1'b1;
            result.slot_byte   <= row.sbyte[slot_k];
            result.slot_count  <= row.scount[slot_k];
            result.entry_total <= row.total;
            result.key_matched <= (row.key == key);
            result.last        <= (slot_k == slot_t'(TOP_SLOTS - 1));
            slot_k             <= slot_k + slot_t'(1);
            if (slot_k == slot_t'(TOP_SLOTS - 1)) state <= S_IDLE;
          end
        end
        S_WR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    probe_cnt <= probe_t'(PROBE_LIMIT) || state != S_CHK)
    else $error("probe count past limit");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLR || state == S_WR))
    else $error("table write outside clear or train");

  a_hash_done: assert property (@(posedge clk) disable iff (rst)
    hstat.done |-> state == S_HASH)
    else $error("hash finished while not waiting");

  a_wr_next: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |=> state == S_IDLE)
    else $error("train did not return to idle");
endmodule
